// ===== src/ffr_pkg.sv =====
// shared types and constants for the fixed frame receiver with reply
package ffr_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_START_CODE    = 2'd0,
      REG_END_CODE      = 2'd1,
      REG_ACK_VALUE     = 2'd2,
      REG_REPLY_COMMAND = 2'd3
   } reg_index_type;

   localparam logic [7:0] START_CODE_RESET    = 8'h02;
   localparam logic [7:0] END_CODE_RESET      = 8'h03;
   localparam logic [7:0] ACK_VALUE_RESET     = 8'hFF;
   localparam logic [7:0] REPLY_COMMAND_RESET = 8'h41;

   typedef enum logic [1:0] {
      ST_IDLE      = 2'd0,
      ST_REP_FETCH = 2'd1,
      ST_REP_SEND  = 2'd2
   } state_type;

endpackage

// ===== src/ffr_ram.sv =====
// generic single write port ram with registered read
module ffr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 13
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/fixed_frame_receiver_with_reply.sv =====
// top level of the fixed frame receiver with reply
//
//   channel | direction | handshake             | words
//   req     | in        | req_valid / req_stall | rx_byte
//   rsp     | out       | rsp_valid / rsp_stall | tx_byte, from_reply, last, tag_value
//   csr     | in / out  | apb write, read       | start_code, end_code, ack_value, reply_command
//
// a byte that causes only its echo is registered in the output register, where the echo
// waits while rsp_stall is high; a byte that completes a reply frame is followed by FRAME_LEN
// reply words, each fetched in ST_REP_FETCH for the registered read of the frame buffer and sent in ST_REP_SEND
// frame sums are kept as the bytes arrive, so the frame is checked as its last byte is accepted
// synchronous reset clears control, config and tag; the frame buffer is not cleared
// req_stall is high while a reply is sent or while an unaccepted word holds the output
module fixed_frame_receiver_with_reply #(
   parameter int FRAME_LEN = 13
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_tx_byte,
   output logic                            rsp_from_reply,
   output logic                            rsp_last,
   output logic [31:0]                     rsp_tag_value,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ffr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ffr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ffr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   localparam int IDX_W = $clog2(FRAME_LEN);
   localparam logic [IDX_W-1:0] K_TAG_LO  = IDX_W'(2);
   localparam logic [IDX_W-1:0] K_TAG_HI  = IDX_W'(5);
   localparam logic [IDX_W-1:0] K_BODY_HI = IDX_W'(FRAME_LEN - 4);
   localparam logic [IDX_W-1:0] K_SUM_HI  = IDX_W'(FRAME_LEN - 3);
   localparam logic [IDX_W-1:0] K_SUM_LO  = IDX_W'(FRAME_LEN - 2);
   localparam logic [IDX_W-1:0] K_LAST    = IDX_W'(FRAME_LEN - 1);

   // config registers
   logic [7:0] start_code_ff;
   logic [7:0] end_code_ff;
   logic [7:0] ack_value_ff;
   logic [7:0] reply_command_ff;

   // control
   ffr_pkg::state_type state_ff, state_in;
   logic              capturing_ff, capturing_in;
   logic [IDX_W-1:0]  fill_ff, fill_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       tag_ff, tag_in;

   // frame datapath
   logic [7:0]        byte0_ff, byte0_in;
   logic [7:0]        cmd_ff, cmd_in;
   logic [31:0]       tag_cand_ff, tag_cand_in;
   logic [7:0]        sum8_ff, sum8_in;
   logic [15:0]       part16_ff, part16_in;
   logic [15:0]       s16_ff, s16_in;

   // output word
   logic [7:0]        tx_ff, tx_in;
   logic              from_reply_ff, from_reply_in;
   logic              last_ff, last_in;
   logic [31:0]       rsp_tag_ff, rsp_tag_in;

   logic              accept;
   logic              slot_free;
   logic              cap_now;
   logic              frame_done;
   logic              frame_ok;
   logic              reply_go;
   logic [7:0]        sum8_new;
   logic              load_echo;
   logic              load_reply;
   logic [7:0]        reply_byte;
   logic [7:0]        ram_rdata;
   logic              csr_write;
   logic [7:0]        csr_rd_byte;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff    <= ffr_pkg::START_CODE_RESET;
         end_code_ff      <= ffr_pkg::END_CODE_RESET;
         ack_value_ff     <= ffr_pkg::ACK_VALUE_RESET;
         reply_command_ff <= ffr_pkg::REPLY_COMMAND_RESET;
      end else if (csr_write) begin
         unique case (ffr_pkg::reg_index_type'(csr_paddr[3:2]))
            ffr_pkg::REG_START_CODE:    start_code_ff    <= csr_pwdata[7:0];
            ffr_pkg::REG_END_CODE:      end_code_ff      <= csr_pwdata[7:0];
            ffr_pkg::REG_ACK_VALUE:     ack_value_ff     <= csr_pwdata[7:0];
            ffr_pkg::REG_REPLY_COMMAND: reply_command_ff <= csr_pwdata[7:0];
            default:                    start_code_ff    <= start_code_ff;
         endcase
      end
   end

   always_comb begin
      unique case (ffr_pkg::reg_index_type'(csr_paddr[3:2]))
         ffr_pkg::REG_START_CODE:    csr_rd_byte = start_code_ff;
         ffr_pkg::REG_END_CODE:      csr_rd_byte = end_code_ff;
         ffr_pkg::REG_ACK_VALUE:     csr_rd_byte = ack_value_ff;
         ffr_pkg::REG_REPLY_COMMAND: csr_rd_byte = reply_command_ff;
         default:                    csr_rd_byte = 8'h00;
      endcase
   end

   assign csr_prdata = {{(ffr_pkg::CSR_DATA_W - 8){1'b0}}, csr_rd_byte};

   // handshakes
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ffr_pkg::ST_IDLE) && slot_free);
   assign accept    = req_valid && !req_stall;

   // frame capture and check
   assign cap_now    = capturing_ff || (req_rx_byte == start_code_ff);
   assign frame_done = cap_now && (fill_ff == K_LAST);
   assign sum8_new   = ((fill_ff == '0) ? 8'h00 : sum8_ff) + req_rx_byte;
   assign frame_ok   = (byte0_ff == start_code_ff) && (req_rx_byte == end_code_ff) &&
                       (sum8_new == ack_value_ff);
   assign reply_go   = frame_done && frame_ok && (cmd_ff == reply_command_ff);

   ffr_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_LEN)
   ) u_frame_ram (
      .clock (clock),
      .we    (accept && cap_now),
      .waddr (fill_ff),
      .wdata (req_rx_byte),
      .raddr (k_ff),
      .rdata (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffr_pkg::ST_IDLE: begin
            if (accept && reply_go) begin
               state_in = ffr_pkg::ST_REP_FETCH;
            end
         end
         ffr_pkg::ST_REP_FETCH: begin
            state_in = ffr_pkg::ST_REP_SEND;
         end
         ffr_pkg::ST_REP_SEND: begin
            if (slot_free) begin
               state_in = (k_ff == K_LAST) ? ffr_pkg::ST_IDLE : ffr_pkg::ST_REP_FETCH;
            end
         end
         default: state_in = ffr_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      load_echo  = 1'b0;
      load_reply = 1'b0;
      k_in       = k_ff;
      unique case (state_ff)
         ffr_pkg::ST_IDLE: begin
            load_echo = accept;
            k_in      = '0;
         end
         ffr_pkg::ST_REP_FETCH: begin
            load_reply = 1'b0;
         end
         ffr_pkg::ST_REP_SEND: begin
            load_reply = slot_free;
            if (slot_free && (k_ff != K_LAST)) begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         default: k_in = '0;
      endcase
   end

   always_comb begin
      if (k_ff == '0) begin
         reply_byte = start_code_ff;
      end else if (k_ff <= K_BODY_HI) begin
         reply_byte = ram_rdata;
      end else if (k_ff == K_SUM_HI) begin
         reply_byte = s16_ff[15:8];
      end else if (k_ff == K_SUM_LO) begin
         reply_byte = s16_ff[7:0];
      end else begin
         reply_byte = end_code_ff;
      end
   end

   // datapath next values
   always_comb begin
      capturing_in  = capturing_ff;
      fill_in       = fill_ff;
      tag_in        = tag_ff;
      byte0_in      = byte0_ff;
      cmd_in        = cmd_ff;
      tag_cand_in   = tag_cand_ff;
      sum8_in       = sum8_ff;
      part16_in     = part16_ff;
      s16_in        = s16_ff;
      tx_in         = tx_ff;
      from_reply_in = from_reply_ff;
      last_in       = last_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (accept && cap_now) begin
         sum8_in = sum8_new;
         if (fill_ff == '0) begin
            byte0_in  = req_rx_byte;
            part16_in = 16'h0000;
         end else if (fill_ff <= K_BODY_HI) begin
            part16_in = part16_ff + {8'h00, req_rx_byte};
         end
         if (fill_ff == IDX_W'(1)) begin
            cmd_in = req_rx_byte;
         end
         if ((fill_ff >= K_TAG_LO) && (fill_ff <= K_TAG_HI)) begin
            tag_cand_in = {tag_cand_ff[23:0], req_rx_byte};
         end
         if (frame_done) begin
            capturing_in = 1'b0;
            fill_in      = '0;
            s16_in       = {8'h00, start_code_ff} + part16_ff + {8'h00, end_code_ff};
         end else begin
            capturing_in = 1'b1;
            fill_in      = fill_ff + IDX_W'(1);
         end
         if (reply_go) begin
            tag_in = tag_cand_ff;
         end
      end

      if (load_echo) begin
         rsp_valid_in  = 1'b1;
         tx_in         = req_rx_byte;
         from_reply_in = 1'b0;
         last_in       = !reply_go;
         rsp_tag_in    = reply_go ? tag_cand_ff : tag_ff;
      end else if (load_reply) begin
         rsp_valid_in  = 1'b1;
         tx_in         = reply_byte;
         from_reply_in = 1'b1;
         last_in       = (k_ff == K_LAST);
         rsp_tag_in    = tag_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffr_pkg::ST_IDLE;
         capturing_ff <= 1'b0;
         fill_ff      <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         tag_ff       <= 32'h0000_0000;
      end else begin
         state_ff     <= state_in;
         capturing_ff <= capturing_in;
         fill_ff      <= fill_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         tag_ff       <= tag_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte0_ff      <= byte0_in;
      cmd_ff        <= cmd_in;
      tag_cand_ff   <= tag_cand_in;
      sum8_ff       <= sum8_in;
      part16_ff     <= part16_in;
      s16_ff        <= s16_in;
      tx_ff         <= tx_in;
      from_reply_ff <= from_reply_in;
      last_ff       <= last_in;
      rsp_tag_ff    <= rsp_tag_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tx_byte    = tx_ff;
   assign rsp_from_reply = from_reply_ff;
   assign rsp_last       = last_ff;
   assign rsp_tag_value  = rsp_tag_ff;

endmodule
